@@ src/rcy_pkg.sv @@
`default_nettype none
package rcy_pkg;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int RW = 31;
  localparam int EW = 16;
  localparam int OW = CW + 1;
  localparam int W_A = 2 * CW;
  localparam int W_H = 2 * CW + 2;
  localparam int W_C = (2 * CW + 3 > RW + FB + 2) ? 2 * CW + 3 : RW + FB + 2;
  localparam int W_D = ((2 * W_H > W_A + 1 + W_C) ? 2 * W_H : W_A + 1 + W_C) + 1;
  localparam int W_Q = (W_D + 1) / 2;
  localparam int W_N = ((W_Q + 1 > W_H) ? W_Q + 1 : W_H) + 1 + FB;
  localparam int W_T = W_N + 1;
  localparam int W_Z = ((W_T + CW > OW + FB) ? W_T + CW : OW + FB) + 1;
  localparam int OUTW = 32;

  localparam int Q_DEPTH = 16;
  localparam int Q_AW = 4;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic [CFG_AW-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_RADIUS_SQ  = 3'd3,
    REG_HALF_HEIGHT = 3'd4,
    REG_EPSILON    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic [RW-1:0]        current_distance;
  } in_t;

  typedef struct packed {
    logic                   hit;
    logic signed [OUTW-1:0] new_distance;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic [RW-1:0]        radius_squared;
    logic [RW-1:0]        half_height;
    logic [EW-1:0]        epsilon;
  } cfg_t;

  typedef struct packed {
    logic                  live;
    logic signed [W_D-1:0] d;
    logic signed [W_H-1:0] h;
    logic [W_A-1:0]        a;
    logic signed [OW-1:0]  oz;
    logic signed [CW-1:0]  dz;
    logic [RW-1:0]         cur;
  } qent_t;

endpackage
`default_nettype wire

@@ src/rcy_mul.sv @@
`default_nettype none
module rcy_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  wire logic                  clk,
  input  wire logic signed [WA-1:0]  a,
  input  wire logic signed [WB-1:0]  b,
  output logic signed [WA+WB-1:0]    p
);

  localparam int LW = 32;
  localparam int NA = (WA + LW - 1) / LW;
  localparam int NB = (WB + LW - 1) / LW;
  localparam int WP = WA + WB;

  logic [WA-1:0]      abs_a;
  logic [WB-1:0]      abs_b;
  logic [NA*LW-1:0]   ma_r;
  logic [NB*LW-1:0]   mb_r;
  logic               neg1_r;
  logic               neg2_r;
  logic [2*LW-1:0]    pp_r [NA*NB];
  logic [WP-1:0]      sum;
  logic signed [WP-1:0] p_r;

  assign abs_a = a[WA-1] ? ($unsigned(~a) + 1'b1) : $unsigned(a);
  assign abs_b = b[WB-1] ? ($unsigned(~b) + 1'b1) : $unsigned(b);

  always_ff @(posedge clk) begin
    ma_r   <= (NA*LW)'(abs_a);
    mb_r   <= (NB*LW)'(abs_b);
    neg1_r <= a[WA-1] ^ b[WB-1];
    neg2_r <= neg1_r;
  end

  for (genvar i = 0; i < NA; i++) begin : g_row
    for (genvar j = 0; j < NB; j++) begin : g_col
      always_ff @(posedge clk) begin
        pp_r[i*NB+j] <= ma_r[i*LW +: LW] * mb_r[j*LW +: LW];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (WP'(pp_r[i*NB+j]) << (LW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= $signed(neg2_r ? (~sum + 1'b1) : sum);
  end

  assign p = p_r;

endmodule
`default_nettype wire

@@ src/rcy_front.sv @@
`default_nettype none
module rcy_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire rcy_pkg::in_t   in_data,
  input  wire rcy_pkg::cfg_t  cfg,
  output logic                push_valid,
  output rcy_pkg::qent_t      push_data
);

  localparam int CW  = rcy_pkg::CW;
  localparam int OW  = rcy_pkg::OW;
  localparam int FB  = rcy_pkg::FB;
  localparam int RW  = rcy_pkg::RW;
  localparam int W_A = rcy_pkg::W_A;
  localparam int W_H = rcy_pkg::W_H;
  localparam int W_C = rcy_pkg::W_C;
  localparam int W_D = rcy_pkg::W_D;
  localparam int LAT = 9;

  typedef struct packed {
    logic signed [OW-1:0] oz;
    logic signed [CW-1:0] dz;
    logic [RW-1:0]        cur;
  } s1_t;

  typedef struct packed {
    logic signed [W_H-1:0] h;
    logic [W_A-1:0]        a;
    s1_t                   s;
  } s2_t;

  logic [LAT-1:0]         vld_r;
  logic signed [OW-1:0]   ox_r, oy_r, oz_r;
  logic signed [CW-1:0]   dx_r, dy_r, dz_r;
  logic [RW-1:0]          cur_r;
  s1_t                    sd1_r [3];
  s1_t                    s5_r;
  s2_t                    sd2_r [3];

  logic signed [2*CW-1:0]  pxx, pyy;
  logic signed [OW+CW-1:0] phx, phy;
  logic signed [2*OW-1:0]  pcx, pcy;

  logic [W_A-1:0]          a_r;
  logic signed [W_H-1:0]   h_r;
  logic signed [W_C-1:0]   c_r;

  logic signed [2*W_H-1:0]     phh;
  logic signed [W_A+1+W_C-1:0] pac;
  logic signed [W_D-1:0]       d_c;
  rcy_pkg::qent_t              q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ox_r  <= {in_data.origin_x[CW-1], in_data.origin_x} - {cfg.center_x[CW-1], cfg.center_x};
    oy_r  <= {in_data.origin_y[CW-1], in_data.origin_y} - {cfg.center_y[CW-1], cfg.center_y};
    oz_r  <= {in_data.origin_z[CW-1], in_data.origin_z} - {cfg.center_z[CW-1], cfg.center_z};
    dx_r  <= in_data.dir_x;
    dy_r  <= in_data.dir_y;
    dz_r  <= in_data.dir_z;
    cur_r <= in_data.current_distance;
  end

  rcy_mul #(.WA(CW), .WB(CW)) u_mxx (.clk(clk), .a(dx_r), .b(dx_r), .p(pxx));
  rcy_mul #(.WA(CW), .WB(CW)) u_myy (.clk(clk), .a(dy_r), .b(dy_r), .p(pyy));
  rcy_mul #(.WA(OW), .WB(CW)) u_mhx (.clk(clk), .a(ox_r), .b(dx_r), .p(phx));
  rcy_mul #(.WA(OW), .WB(CW)) u_mhy (.clk(clk), .a(oy_r), .b(dy_r), .p(phy));
  rcy_mul #(.WA(OW), .WB(OW)) u_mcx (.clk(clk), .a(ox_r), .b(ox_r), .p(pcx));
  rcy_mul #(.WA(OW), .WB(OW)) u_mcy (.clk(clk), .a(oy_r), .b(oy_r), .p(pcy));

  always_ff @(posedge clk) begin
    sd1_r[0] <= '{oz: oz_r, dz: dz_r, cur: cur_r};
    sd1_r[1] <= sd1_r[0];
    sd1_r[2] <= sd1_r[1];
  end

  always_ff @(posedge clk) begin
    a_r  <= W_A'($unsigned(pxx) + $unsigned(pyy));
    h_r  <= W_H'(phx) + W_H'(phy);
    c_r  <= W_C'(pcx) + W_C'(pcy) - W_C'({cfg.radius_squared, {FB{1'b0}}});
    s5_r <= sd1_r[2];
  end

  rcy_mul #(.WA(W_H), .WB(W_H)) u_mhh (.clk(clk), .a(h_r), .b(h_r), .p(phh));
  rcy_mul #(.WA(W_A+1), .WB(W_C)) u_mac (
    .clk(clk), .a($signed({1'b0, a_r})), .b(c_r), .p(pac)
  );

  always_ff @(posedge clk) begin
    sd2_r[0] <= '{h: h_r, a: a_r, s: s5_r};
    sd2_r[1] <= sd2_r[0];
    sd2_r[2] <= sd2_r[1];
  end

  assign d_c = W_D'(phh) - W_D'(pac);

  always_ff @(posedge clk) begin
    q_r.live <= (sd2_r[2].a != '0) && !d_c[W_D-1];
    q_r.d    <= d_c;
    q_r.h    <= sd2_r[2].h;
    q_r.a    <= sd2_r[2].a;
    q_r.oz   <= sd2_r[2].s.oz;
    q_r.dz   <= sd2_r[2].s.dz;
    q_r.cur  <= sd2_r[2].s.cur;
  end

  assign push_valid = vld_r[LAT-1];
  assign push_data  = q_r;

endmodule
`default_nettype wire

@@ src/rcy_queue.sv @@
`default_nettype none
module rcy_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  input  wire rcy_pkg::qent_t  push_data,
  output logic                 pop_valid,
  output rcy_pkg::qent_t       pop_data
);

  localparam int AW = rcy_pkg::Q_AW;

  rcy_pkg::qent_t    mem [rcy_pkg::Q_DEPTH];
  logic [AW-1:0]     wp_r, rp_r;
  logic [AW:0]       cnt_r;
  logic              pop;
  logic              pv_r;
  rcy_pkg::qent_t    pd_r;

  assign pop = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pd_r <= mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      pv_r  <= 1'b0;
    end else begin
      wp_r  <= wp_r + AW'(push_valid);
      rp_r  <= rp_r + AW'(pop);
      cnt_r <= cnt_r + (AW+1)'(push_valid) - (AW+1)'(pop);
      pv_r  <= pop;
    end
  end

  assign pop_valid = pv_r;
  assign pop_data  = pd_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (cnt_r != (AW+1)'(rcy_pkg::Q_DEPTH)) || pop)
    else $error("queue overflow");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(rcy_pkg::Q_DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

@@ src/rcy_back.sv @@
`default_nettype none
module rcy_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire rcy_pkg::qent_t  in_data,
  input  wire rcy_pkg::cfg_t   cfg,
  output logic                 out_valid,
  output rcy_pkg::out_t        out_data
);

  localparam int CW   = rcy_pkg::CW;
  localparam int OW   = rcy_pkg::OW;
  localparam int FB   = rcy_pkg::FB;
  localparam int RW   = rcy_pkg::RW;
  localparam int W_A  = rcy_pkg::W_A;
  localparam int W_H  = rcy_pkg::W_H;
  localparam int W_Q  = rcy_pkg::W_Q;
  localparam int W_N  = rcy_pkg::W_N;
  localparam int W_T  = rcy_pkg::W_T;
  localparam int W_Z  = rcy_pkg::W_Z;
  localparam int OUTW = rcy_pkg::OUTW;
  localparam int LAT  = W_Q + W_N + 7;

  typedef struct packed {
    logic                  live;
    logic signed [W_H-1:0] h;
    logic [W_A-1:0]        a;
    logic signed [OW-1:0]  oz;
    logic signed [CW-1:0]  dz;
    logic [RW-1:0]         cur;
  } bs_t;

  typedef struct packed {
    logic neg0;
    logic neg1;
    bs_t  s;
  } ds_t;

  typedef struct packed {
    logic signed [W_T-1:0] t0;
    logic signed [W_T-1:0] t1;
    bs_t                   s;
  } zs_t;

  typedef struct packed {
    logic            live;
    logic            n0;
    logic            n1;
    logic            c0;
    logic            c1;
    logic            lt0;
    logic            lt1;
    logic            le1;
    logic [OUTW-1:0] t0lo;
    logic [OUTW-1:0] t1lo;
    logic [RW-1:0]   cur;
  } fl_t;

  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // square root, one result bit per stage
  logic [W_Q+2:0]   rem_r  [W_Q];
  logic [W_Q-1:0]   root_r [W_Q];
  logic [2*W_Q-1:0] dsh_r  [W_Q];
  bs_t              ss_r   [W_Q];

  for (genvar k = 0; k < W_Q; k++) begin : g_sqrt
    logic [W_Q+2:0]   r_in, r_sh, trial;
    logic [W_Q-1:0]   q_in;
    logic [2*W_Q-1:0] d_in;
    bs_t              s_in;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign d_in = (2*W_Q)'($unsigned(in_data.d));
      assign s_in = '{live: in_data.live, h: in_data.h, a: in_data.a,
                      oz: in_data.oz, dz: in_data.dz, cur: in_data.cur};
    end else begin : g_next
      assign r_in = rem_r[k-1];
      assign q_in = root_r[k-1];
      assign d_in = dsh_r[k-1];
      assign s_in = ss_r[k-1];
    end

    assign r_sh  = {r_in[W_Q:0], d_in[2*W_Q-1 -: 2]};
    assign trial = (W_Q+3)'({q_in, 2'b01});
    assign ge    = (r_sh >= trial);

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? (r_sh - trial) : r_sh;
      root_r[k] <= {q_in[W_Q-2:0], ge};
      dsh_r[k]  <= d_in << 2;
      ss_r[k]   <= s_in;
    end
  end

  // numerators of both roots
  logic signed [W_N-1:0] qx, hx, n1, n0;
  logic [W_N-1:0]        pm0_r, pm1_r;
  ds_t                   pd_r;

  assign qx = W_N'($signed({1'b0, root_r[W_Q-1]}));
  assign hx = W_N'(ss_r[W_Q-1].h);
  assign n1 = (qx - hx) <<< FB;
  assign n0 = (-(hx + qx)) <<< FB;

  always_ff @(posedge clk) begin
    pm1_r <= n1[W_N-1] ? $unsigned(-n1) : $unsigned(n1);
    pm0_r <= n0[W_N-1] ? $unsigned(-n0) : $unsigned(n0);
    pd_r  <= '{neg0: n0[W_N-1], neg1: n1[W_N-1], s: ss_r[W_Q-1]};
  end

  // two restoring dividers, one quotient bit per stage
  logic [W_A:0]   r0_r [W_N];
  logic [W_A:0]   r1_r [W_N];
  logic [W_N-1:0] q0_r [W_N];
  logic [W_N-1:0] q1_r [W_N];
  logic [W_N-1:0] m0_r [W_N];
  logic [W_N-1:0] m1_r [W_N];
  ds_t            dv_r [W_N];

  for (genvar j = 0; j < W_N; j++) begin : g_div
    logic [W_A:0]   r0_in, r1_in, r0_sh, r1_sh, den;
    logic [W_N-1:0] q0_in, q1_in, m0_in, m1_in;
    ds_t            s_in;
    logic           ge0, ge1;

    if (j == 0) begin : g_first
      assign r0_in = '0;
      assign r1_in = '0;
      assign q0_in = '0;
      assign q1_in = '0;
      assign m0_in = pm0_r;
      assign m1_in = pm1_r;
      assign s_in  = pd_r;
    end else begin : g_next
      assign r0_in = r0_r[j-1];
      assign r1_in = r1_r[j-1];
      assign q0_in = q0_r[j-1];
      assign q1_in = q1_r[j-1];
      assign m0_in = m0_r[j-1];
      assign m1_in = m1_r[j-1];
      assign s_in  = dv_r[j-1];
    end

    assign den   = {1'b0, s_in.s.a};
    assign r0_sh = {r0_in[W_A-1:0], m0_in[W_N-1]};
    assign r1_sh = {r1_in[W_A-1:0], m1_in[W_N-1]};
    assign ge0   = (r0_sh >= den);
    assign ge1   = (r1_sh >= den);

    always_ff @(posedge clk) begin
      r0_r[j] <= ge0 ? (r0_sh - den) : r0_sh;
      r1_r[j] <= ge1 ? (r1_sh - den) : r1_sh;
      q0_r[j] <= {q0_in[W_N-2:0], ge0};
      q1_r[j] <= {q1_in[W_N-2:0], ge1};
      m0_r[j] <= m0_in << 1;
      m1_r[j] <= m1_in << 1;
      dv_r[j] <= s_in;
    end
  end

  // round toward minus infinity
  logic signed [W_T-1:0] tq0, tq1;
  logic signed [W_T-1:0] ft0_r, ft1_r;
  bs_t                   fs_r;

  assign tq0 = $signed({1'b0, q0_r[W_N-1]});
  assign tq1 = $signed({1'b0, q1_r[W_N-1]});

  always_ff @(posedge clk) begin
    ft0_r <= dv_r[W_N-1].neg0 ? (-tq0 - $signed(W_T'(r0_r[W_N-1] != '0))) : tq0;
    ft1_r <= dv_r[W_N-1].neg1 ? (-tq1 - $signed(W_T'(r1_r[W_N-1] != '0))) : tq1;
    fs_r  <= dv_r[W_N-1].s;
  end

  logic signed [W_T+CW-1:0] pz0, pz1;

  rcy_mul #(.WA(W_T), .WB(CW)) u_mz0 (.clk(clk), .a(ft0_r), .b(fs_r.dz), .p(pz0));
  rcy_mul #(.WA(W_T), .WB(CW)) u_mz1 (.clk(clk), .a(ft1_r), .b(fs_r.dz), .p(pz1));

  zs_t zs_r [3];

  always_ff @(posedge clk) begin
    zs_r[0] <= '{t0: ft0_r, t1: ft1_r, s: fs_r};
    zs_r[1] <= zs_r[0];
    zs_r[2] <= zs_r[1];
  end

  // z test and distance compares
  logic signed [W_Z-1:0] ozs, z0, z1;
  logic [W_Z-1:0]        az0, az1, hhs;
  logic signed [W_T-1:0] curx;
  fl_t                   fl_r;

  assign ozs  = W_Z'(zs_r[2].s.oz) <<< FB;
  assign z0   = W_Z'(pz0) + ozs;
  assign z1   = W_Z'(pz1) + ozs;
  assign az0  = z0[W_Z-1] ? $unsigned(-z0) : $unsigned(z0);
  assign az1  = z1[W_Z-1] ? $unsigned(-z1) : $unsigned(z1);
  assign hhs  = W_Z'({cfg.half_height, {FB{1'b0}}});
  assign curx = $signed(W_T'(zs_r[2].s.cur));

  always_ff @(posedge clk) begin
    fl_r.live <= zs_r[2].s.live;
    fl_r.n0   <= zs_r[2].t0[W_T-1];
    fl_r.n1   <= zs_r[2].t1[W_T-1];
    fl_r.c0   <= zs_r[2].t0 < curx;
    fl_r.c1   <= zs_r[2].t1 < curx;
    fl_r.lt0  <= az0 < hhs;
    fl_r.lt1  <= az1 < hhs;
    fl_r.le1  <= az1 <= hhs;
    fl_r.t0lo <= zs_r[2].t0[OUTW-1:0];
    fl_r.t1lo <= zs_r[2].t1[OUTW-1:0];
    fl_r.cur  <= zs_r[2].s.cur;
  end

  // pick the root
  logic            hit;
  logic [OUTW-1:0] chosen;
  rcy_pkg::out_t   o_r;

  always_comb begin
    hit    = 1'b0;
    chosen = fl_r.t0lo;
    if (fl_r.live) begin
      if (fl_r.n0) begin
        if (!fl_r.n1 && fl_r.c1 && fl_r.le1) begin
          hit    = 1'b1;
          chosen = fl_r.t1lo;
        end
      end else if (fl_r.c0) begin
        if (fl_r.lt0) begin
          hit    = 1'b1;
          chosen = fl_r.t0lo;
        end else if (fl_r.c1 && fl_r.lt1) begin
          hit    = 1'b1;
          chosen = fl_r.t1lo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    o_r.hit          <= hit;
    o_r.new_distance <= hit ? $signed(chosen - OUTW'(cfg.epsilon))
                            : $signed(OUTW'(fl_r.cur));
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = o_r;

  a_miss_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.new_distance[OUTW-1] == 1'b0))
    else $error("miss must pass the distance through");

endmodule
`default_nettype wire

@@ src/ray_cylinder_intersect_core.sv @@
`default_nettype none
// Ray against z-aligned uncapped cylinder, fully pipelined.
// Throughput: one transaction per cycle; busy stays low in steady flow.
// Path from start to out_strobe: front, queue,
// square root 67 stages, two dividers 85 stages, then numerators, rounding, z test and select.
// Synchronous active-low reset clears control state and loads register defaults.
// Results appear for one cycle on out_strobe; the receiver cannot stall.
module ray_cylinder_intersect_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire rcy_pkg::in_t                  in_data,
  output logic                               out_strobe,
  output rcy_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [rcy_pkg::CFG_AW-1:0]    cfg_index,
  input  wire logic [rcy_pkg::CFG_DW-1:0]    cfg_wdata
);

  localparam int AW = rcy_pkg::Q_AW;

  rcy_pkg::cfg_t   cfg_r;
  logic [AW:0]     credit_r;
  logic            accept;
  logic            push_valid;
  rcy_pkg::qent_t  push_data;
  logic            pop_valid;
  rcy_pkg::qent_t  pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x       <= '0;
      cfg_r.center_y       <= '0;
      cfg_r.center_z       <= '0;
      cfg_r.radius_squared <= rcy_pkg::RW'(65536);
      cfg_r.half_height    <= rcy_pkg::RW'(65536);
      cfg_r.epsilon        <= rcy_pkg::EW'(66);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcy_pkg::REG_CENTER_X:    cfg_r.center_x       <= cfg_wdata[rcy_pkg::CW-1:0];
        rcy_pkg::REG_CENTER_Y:    cfg_r.center_y       <= cfg_wdata[rcy_pkg::CW-1:0];
        rcy_pkg::REG_CENTER_Z:    cfg_r.center_z       <= cfg_wdata[rcy_pkg::CW-1:0];
        rcy_pkg::REG_RADIUS_SQ:   cfg_r.radius_squared <= cfg_wdata[rcy_pkg::RW-1:0];
        rcy_pkg::REG_HALF_HEIGHT: cfg_r.half_height    <= cfg_wdata[rcy_pkg::RW-1:0];
        rcy_pkg::REG_EPSILON:     cfg_r.epsilon        <= cfg_wdata[rcy_pkg::EW-1:0];
        default: ;
      endcase
    end
  end

  assign busy   = (credit_r == (AW+1)'(rcy_pkg::Q_DEPTH));
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_r + (AW+1)'(accept) - (AW+1)'(pop_valid);
    end
  end

  rcy_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(accept), .in_data(in_data), .cfg(cfg_r),
    .push_valid(push_valid), .push_data(push_data)
  );

  rcy_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push_valid(push_valid), .push_data(push_data),
    .pop_valid(pop_valid), .pop_data(pop_data)
  );

  rcy_back u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(pop_valid), .in_data(pop_data), .cfg(cfg_r),
    .out_valid(out_strobe), .out_data(out_data)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= (AW+1)'(rcy_pkg::Q_DEPTH))
    else $error("credit count out of range");

endmodule
`default_nettype wire
